/* rtl/core/sfd_pkg.sv */
// Shared constants and the CRC-16 byte update for the frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

   localparam int HDR_BYTES      = 24;
   localparam int POS_WIDTH      = 18;
   localparam int LEN_WIDTH      = POS_WIDTH + 1;
   localparam int MAX_LEN_WIDTH  = 17;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int HDR_IDX_WIDTH  = 5;

   localparam logic [POS_WIDTH-1:0]     POS_MAX        = 18'h3FFFF;
   localparam logic [POS_WIDTH-1:0]     LAST_HDR_POS   = 18'd23;
   localparam logic [LEN_WIDTH-1:0]     MIN_FRAME_LEN  = 19'd26;
   localparam logic [LEN_WIDTH-1:0]     CRC_LEN        = 19'd2;
   localparam logic [MAX_LEN_WIDTH-1:0] MAX_FRAME_INIT = 17'd130076;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAGIC_FIRST  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAGIC_SECOND = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VERSION      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SAMPLE_TYPE  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_HEARTBEAT    = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAX_FRAME    = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FRAMING = 2'd1;
   localparam logic [1:0] STATUS_CRC     = 2'd2;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // One byte of CRC-16/CCITT-FALSE, MSB first, no reflection.
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

/* rtl/core/sfd_crc16.sv */
// CRC-16 accumulator with a two-byte holdback that keeps the trailing CRC out of the sum.
`timescale 1ns / 1ps

module sfd_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        feed,
   input  logic        frame_end,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_value,
   output logic [7:0]  held_byte
);

   logic [15:0] crc_ff, crc_in;
   logic [15:0] hold_ff, hold_in;
   logic [1:0]  fill_ff, fill_in;

   // The oldest held byte joins the CRC once two newer bytes have arrived.
   assign crc_value = (fill_ff == 2'd2) ? sfd_pkg::crc16_feed(crc_ff, hold_ff[7:0]) : crc_ff;
   assign held_byte = hold_ff[15:8];

   always_comb begin
      crc_in  = crc_ff;
      hold_in = hold_ff;
      fill_in = fill_ff;
      if (feed) begin
         if (frame_end) begin
            crc_in  = sfd_pkg::CRC_INIT;
            hold_in = 16'h0000;
            fill_in = 2'd0;
         end else begin
            crc_in  = crc_value;
            hold_in = {data_byte, hold_ff[15:8]};
            fill_in = (fill_ff == 2'd2) ? fill_ff : fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= sfd_pkg::CRC_INIT;
         hold_ff <= 16'h0000;
         fill_ff <= 2'd0;
      end else begin
         crc_ff  <= crc_in;
         hold_ff <= hold_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* rtl/core/sample_frame_deframer_crc16.sv */
// Byte-serial deframer: header capture, sample extraction and the frame verdict.
// A result is registered; it shows on rsp in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register is refilled in the same cycle
// it is drained, so only a stalled rsp channel holds the input back.
// Reset clears all frame state but end_ff and loads the configuration registers with their
// defaults (max frame length 130076, all codes zero); no clearing pass is needed.
`timescale 1ns / 1ps

module sample_frame_deframer_crc16 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_result_kind,
   output logic signed [15:0] rsp_sample_value,
   output logic [15:0]        rsp_sample_index,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_message_type,
   output logic [15:0]        rsp_node_id,
   output logic [31:0]        rsp_sequence_res,
   output logic [63:0]        rsp_node_time_us,
   output logic [31:0]        rsp_rate_hz,
   output logic [7:0]         rsp_channels,
   output logic [7:0]         rsp_samples_per_channel,
   input  logic               csr_wr_en,
   input  logic [sfd_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [sfd_pkg::MAX_LEN_WIDTH-1:0] csr_data
);

   // Configuration registers.
   logic [7:0] magic_first_ff, magic_second_ff, version_ff, sample_type_ff, heartbeat_ff;
   logic [sfd_pkg::MAX_LEN_WIDTH-1:0] max_frame_ff;

   // Frame state.
   logic [sfd_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic [sfd_pkg::POS_WIDTH-1:0] end_ff, end_in;
   logic [7:0]  pend_ff, pend_in;
   logic [15:0] seen_ff, seen_in;
   logic        hbad_ff, hbad_in;
   logic [7:0]  hdr_ff [sfd_pkg::HDR_BYTES];
   logic [7:0]  hdr_in [sfd_pkg::HDR_BYTES];

   // Output register.
   logic               rsp_valid_ff;
   logic               kind_ff;
   logic signed [15:0] value_ff;
   logic [15:0]        index_ff;
   logic [1:0]         status_ff;
   logic [7:0]         mtype_ff;
   logic [15:0]        node_ff;
   logic [31:0]        seq_ff;
   logic [63:0]        time_ff;
   logic [31:0]        rate_ff;
   logic [7:0]         chan_ff;
   logic [7:0]         spc_ff;

   logic        accept;
   logic        last;
   logic        in_header;
   logic        in_payload;
   logic        byte_bad;
   logic        emit;
   logic        framing_err;
   logic [sfd_pkg::LEN_WIDTH-1:0] frame_len;
   logic [15:0] sample_total;
   logic [15:0] crc_value;
   logic [7:0]  held_byte;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign last      = req_frame_end;

   sfd_crc16 u_crc (
      .clock     (clock),
      .reset     (reset),
      .feed      (accept),
      .frame_end (last),
      .data_byte (req_data_byte),
      .crc_value (crc_value),
      .held_byte (held_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff  <= 8'h00;
         magic_second_ff <= 8'h00;
         version_ff      <= 8'h00;
         sample_type_ff  <= 8'h00;
         heartbeat_ff    <= 8'h00;
         max_frame_ff    <= sfd_pkg::MAX_FRAME_INIT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sfd_pkg::REG_MAGIC_FIRST:  magic_first_ff  <= csr_data[7:0];
            sfd_pkg::REG_MAGIC_SECOND: magic_second_ff <= csr_data[7:0];
            sfd_pkg::REG_VERSION:      version_ff      <= csr_data[7:0];
            sfd_pkg::REG_SAMPLE_TYPE:  sample_type_ff  <= csr_data[7:0];
            sfd_pkg::REG_HEARTBEAT:    heartbeat_ff    <= csr_data[7:0];
            sfd_pkg::REG_MAX_FRAME:    max_frame_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign in_header  = pos_ff < sfd_pkg::POS_WIDTH'(sfd_pkg::HDR_BYTES);
   assign in_payload = !in_header && (pos_ff < end_ff);
   assign emit       = in_payload && pos_ff[0] && !last;

   // Header bytes as they stand after this byte, so a short frame reports what it carried.
   always_comb begin
      for (int i = 0; i < sfd_pkg::HDR_BYTES; i++) begin
         hdr_in[i] = (in_header && pos_ff[sfd_pkg::HDR_IDX_WIDTH-1:0] ==
                      sfd_pkg::HDR_IDX_WIDTH'(i)) ? req_data_byte : hdr_ff[i];
      end
   end

   always_comb begin
      byte_bad = 1'b0;
      if (pos_ff == 18'd0) begin
         byte_bad = req_data_byte != magic_first_ff;
      end else if (pos_ff == 18'd1) begin
         byte_bad = req_data_byte != magic_second_ff;
      end else if (pos_ff == 18'd2) begin
         byte_bad = req_data_byte != version_ff;
      end else if (pos_ff == 18'd3) begin
         byte_bad = (req_data_byte != sample_type_ff) && (req_data_byte != heartbeat_ff);
      end
   end

   // The payload end is fixed once the sample count byte arrives.
   assign sample_total = hdr_ff[22] * req_data_byte;
   assign end_in = (pos_ff == sfd_pkg::LAST_HDR_POS)
                 ? sfd_pkg::POS_WIDTH'(sfd_pkg::HDR_BYTES) + {1'b0, sample_total, 1'b0}
                 : end_ff;

   assign frame_len = {1'b0, pos_ff} + 19'd1;
   assign hbad_in   = hbad_ff || byte_bad;

   // A frame shorter than a header leaves end_ff stale, but the length check catches it.
   assign framing_err = (frame_len < sfd_pkg::MIN_FRAME_LEN)
                     || (frame_len > {2'b00, max_frame_ff})
                     || (pos_ff == sfd_pkg::POS_MAX)
                     || hbad_in
                     || (frame_len != {1'b0, end_ff} + sfd_pkg::CRC_LEN);

   always_comb begin
      pos_in  = pos_ff;
      pend_in = pend_ff;
      seen_in = seen_ff;
      if (last) begin
         pos_in  = '0;
         pend_in = 8'h00;
         seen_in = 16'h0000;
      end else begin
         pos_in = (pos_ff == sfd_pkg::POS_MAX) ? pos_ff : pos_ff + 18'd1;
         if (in_payload && !pos_ff[0]) begin
            pend_in = req_data_byte;
         end
         if (emit) begin
            seen_in = seen_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pend_ff <= 8'h00;
         seen_ff <= 16'h0000;
         hbad_ff <= 1'b0;
         for (int i = 0; i < sfd_pkg::HDR_BYTES; i++) begin
            hdr_ff[i] <= 8'h00;
         end
      end else if (accept) begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         seen_ff <= seen_in;
         hbad_ff <= last ? 1'b0 : hbad_in;
         for (int i = 0; i < sfd_pkg::HDR_BYTES; i++) begin
            hdr_ff[i] <= last ? 8'h00 : hdr_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         end_ff <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && (last || emit)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (last || emit)) begin
         if (last) begin
            kind_ff  <= sfd_pkg::KIND_VERDICT;
            value_ff <= 16'sd0;
            index_ff <= 16'h0000;
            if (framing_err) begin
               status_ff <= sfd_pkg::STATUS_FRAMING;
            end else if ({req_data_byte, held_byte} != crc_value) begin
               status_ff <= sfd_pkg::STATUS_CRC;
            end else begin
               status_ff <= sfd_pkg::STATUS_OK;
            end
            mtype_ff <= hdr_in[3];
            node_ff  <= {hdr_in[5], hdr_in[4]};
            seq_ff   <= {hdr_in[9], hdr_in[8], hdr_in[7], hdr_in[6]};
            time_ff  <= {hdr_in[17], hdr_in[16], hdr_in[15], hdr_in[14],
                         hdr_in[13], hdr_in[12], hdr_in[11], hdr_in[10]};
            rate_ff  <= {hdr_in[21], hdr_in[20], hdr_in[19], hdr_in[18]};
            chan_ff  <= hdr_in[22];
            spc_ff   <= hdr_in[23];
         end else begin
            kind_ff   <= sfd_pkg::KIND_SAMPLE;
            value_ff  <= $signed({req_data_byte, pend_ff});
            index_ff  <= seen_ff;
            status_ff <= sfd_pkg::STATUS_OK;
            mtype_ff  <= 8'h00;
            node_ff   <= 16'h0000;
            seq_ff    <= 32'h0;
            time_ff   <= 64'h0;
            rate_ff   <= 32'h0;
            chan_ff   <= 8'h00;
            spc_ff    <= 8'h00;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result_kind         = kind_ff;
   assign rsp_sample_value        = value_ff;
   assign rsp_sample_index        = index_ff;
   assign rsp_status              = status_ff;
   assign rsp_message_type        = mtype_ff;
   assign rsp_node_id             = node_ff;
   assign rsp_sequence_res        = seq_ff;
   assign rsp_node_time_us        = time_ff;
   assign rsp_rate_hz             = rate_ff;
   assign rsp_channels            = chan_ff;
   assign rsp_samples_per_channel = spc_ff;

endmodule

/* test/tb_sample_frame_deframer_crc16.sv */
// Self-checking testbench for the sample frame deframer with CRC-16 check.
`timescale 1ns / 1ps

module tb_sample_frame_deframer_crc16;

   localparam logic [7:0] TYPE_SAMPLES   = 8'h10;
   localparam logic [7:0] TYPE_HEARTBEAT = 8'h20;
   localparam logic [sfd_pkg::CSR_IDX_WIDTH-1:0] REG_UNMAPPED_LO =
      sfd_pkg::REG_MAX_FRAME + 3'd1;
   localparam logic [sfd_pkg::CSR_IDX_WIDTH-1:0] REG_UNMAPPED_HI =
      sfd_pkg::REG_MAX_FRAME + 3'd2;
   localparam int         RANDOM_BYTES   = 150;
   localparam int         WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic        kind;
      logic [15:0] value;
      logic [15:0] index;
      logic [1:0]  status;
      logic [7:0]  mtype;
      logic [15:0] node_id;
      logic [31:0] seq_num;
      logic [63:0] time_us;
      logic [31:0] rate;
      logic [7:0]  chans;
      logic [7:0]  spc;
   } deframe_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [7:0]                          req_data_byte = '0;
   logic                                req_frame_end = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_result_kind;
   logic signed [15:0]                  rsp_sample_value;
   logic [15:0]                         rsp_sample_index;
   logic [1:0]                          rsp_status;
   logic [7:0]                          rsp_message_type;
   logic [15:0]                         rsp_node_id;
   logic [31:0]                         rsp_sequence_res;
   logic [63:0]                         rsp_node_time_us;
   logic [31:0]                         rsp_rate_hz;
   logic [7:0]                          rsp_channels;
   logic [7:0]                          rsp_samples_per_channel;
   logic                                csr_wr_en = 1'b0;
   logic [sfd_pkg::CSR_IDX_WIDTH-1:0]   csr_index = '0;
   logic [sfd_pkg::MAX_LEN_WIDTH-1:0]   csr_data = '0;

   // Configuration as the predictor sees it.
   logic [7:0]                          cfg_magic_first = '0;
   logic [7:0]                          cfg_magic_second = '0;
   logic [7:0]                          cfg_version = '0;
   logic [7:0]                          cfg_sample_type = '0;
   logic [7:0]                          cfg_heartbeat_type = '0;
   logic [sfd_pkg::MAX_LEN_WIDTH-1:0]   cfg_max_frame = sfd_pkg::MAX_FRAME_INIT;

   // Frame state of the predictor.
   logic [sfd_pkg::POS_WIDTH-1:0]       frame_pos;
   logic [15:0]                         crc_acc;
   logic [15:0]                         hold_bytes;
   logic [1:0]                          hold_fill;
   logic [7:0]                          hdr_bytes [sfd_pkg::HDR_BYTES];
   logic [7:0]                          pend_low;
   logic [15:0]                         samples_seen;
   logic                                hdr_bad;

   deframe_result_type                  results_due [$];
   logic [7:0]                          frame_buf [$];
   int unsigned                         mismatch_count = 0;
   int unsigned                         bytes_sent = 0;
   int unsigned                         quiet_cycles = 0;
   logic                                idle_enable = 1'b1;

   sample_frame_deframer_crc16 i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_data_byte           (req_data_byte),
      .req_frame_end           (req_frame_end),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_result_kind         (rsp_result_kind),
      .rsp_sample_value        (rsp_sample_value),
      .rsp_sample_index        (rsp_sample_index),
      .rsp_status              (rsp_status),
      .rsp_message_type        (rsp_message_type),
      .rsp_node_id             (rsp_node_id),
      .rsp_sequence_res        (rsp_sequence_res),
      .rsp_node_time_us        (rsp_node_time_us),
      .rsp_rate_hz             (rsp_rate_hz),
      .rsp_channels            (rsp_channels),
      .rsp_samples_per_channel (rsp_samples_per_channel),
      .csr_wr_en               (csr_wr_en),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= idle_enable ? ($urandom_range(0, 99) >= 33) : 1'b1;
   end

   function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r  = {r[14:0], 1'b0};
         if (fb) begin
            r = r ^ sfd_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] hdr_field(input int first, input int count);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < count; i++) begin
         v = v | (64'(hdr_bytes[first + i]) << (8 * i));
      end
      return v;
   endfunction

   task automatic clear_frame();
      frame_pos    = '0;
      crc_acc      = sfd_pkg::CRC_INIT;
      hold_bytes   = '0;
      hold_fill    = '0;
      foreach (hdr_bytes[i]) begin
         hdr_bytes[i] = '0;
      end
      pend_low     = '0;
      samples_seen = '0;
      hdr_bad      = 1'b0;
   endtask

   // Advances the frame state by one accepted byte and queues any result it causes.
   task automatic deframe_byte(input logic [7:0] b, input logic last);
      int                 p;
      int                 payload_end;
      int                 frame_len;
      logic               emit;
      logic [15:0]        value;
      logic [15:0]        received_crc;
      deframe_result_type r;
      p           = int'(frame_pos);
      payload_end = sfd_pkg::HDR_BYTES + 2 * int'(hdr_bytes[22]) * int'(hdr_bytes[23]);
      r           = '0;
      emit        = 1'b0;
      value       = '0;
      if (p < sfd_pkg::HDR_BYTES) begin
         hdr_bytes[p] = b;
         if ((p == 0 && b != cfg_magic_first) || (p == 1 && b != cfg_magic_second) ||
             (p == 2 && b != cfg_version) ||
             (p == 3 && b != cfg_sample_type && b != cfg_heartbeat_type)) begin
            hdr_bad = 1'b1;
         end
      end else if (p < payload_end) begin
         if (((p - sfd_pkg::HDR_BYTES) % 2) == 0) begin
            pend_low = b;
         end else if (!last) begin
            emit  = 1'b1;
            value = {b, pend_low};
         end
      end
      // The CRC lags two bytes behind so that the trailing CRC field stays out of it.
      if (hold_fill >= 2) begin
         crc_acc = crc_update(crc_acc, hold_bytes[7:0]);
      end
      if (last) begin
         frame_len    = p + 1;
         received_crc = {b, hold_bytes[15:8]};
         r.kind       = sfd_pkg::KIND_VERDICT;
         if (frame_len < int'(sfd_pkg::MIN_FRAME_LEN) || frame_len > int'(cfg_max_frame) ||
             p >= int'(sfd_pkg::POS_MAX) || hdr_bad || frame_len != payload_end + 2) begin
            r.status = sfd_pkg::STATUS_FRAMING;
         end else if (received_crc != crc_acc) begin
            r.status = sfd_pkg::STATUS_CRC;
         end else begin
            r.status = sfd_pkg::STATUS_OK;
         end
         r.mtype   = hdr_bytes[3];
         r.node_id = 16'(hdr_field(4, 2));
         r.seq_num = 32'(hdr_field(6, 4));
         r.time_us = hdr_field(10, 8);
         r.rate    = 32'(hdr_field(18, 4));
         r.chans   = hdr_bytes[22];
         r.spc     = hdr_bytes[23];
         results_due.push_back(r);
         clear_frame();
      end else begin
         hold_bytes = {b, hold_bytes[15:8]};
         if (hold_fill < 2) begin
            hold_fill = hold_fill + 1'b1;
         end
         if (p < int'(sfd_pkg::POS_MAX)) begin
            frame_pos = frame_pos + 1'b1;
         end
         if (emit) begin
            r.kind  = sfd_pkg::KIND_SAMPLE;
            r.value = value;
            r.index = samples_seen;
            samples_seen = samples_seen + 1'b1;
            results_due.push_back(r);
         end
      end
   endtask

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      deframe_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: result transaction with nothing expected, kind %0d", $time,
                     rsp_result_kind);
            mismatch_count++;
         end else begin
            due = results_due.pop_front();
            compare_field("result_kind", 64'(due.kind), 64'(rsp_result_kind));
            compare_field("sample_value", 64'(due.value), 64'($unsigned(rsp_sample_value)));
            compare_field("sample_index", 64'(due.index), 64'(rsp_sample_index));
            compare_field("status", 64'(due.status), 64'(rsp_status));
            compare_field("message_type", 64'(due.mtype), 64'(rsp_message_type));
            compare_field("node_id", 64'(due.node_id), 64'(rsp_node_id));
            compare_field("sequence_res", 64'(due.seq_num), 64'(rsp_sequence_res));
            compare_field("node_time_us", due.time_us, rsp_node_time_us);
            compare_field("rate_hz", 64'(due.rate), 64'(rsp_rate_hz));
            compare_field("channels", 64'(due.chans), 64'(rsp_channels));
            compare_field("samples_per_channel", 64'(due.spc),
                          64'(rsp_samples_per_channel));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, no transaction for %0d cycles", $time, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_enable) begin
         while ($urandom_range(0, 99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_frame_end <= last;
      do begin
         @(posedge clock);
      end while (!req_ready);
      bytes_sent++;
      deframe_byte(b, last);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) begin
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      end
   endtask

   // Lets every expected transaction arrive, then a few cycles for the output register.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sfd_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [sfd_pkg::MAX_LEN_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         sfd_pkg::REG_MAGIC_FIRST:  cfg_magic_first    = value[7:0];
         sfd_pkg::REG_MAGIC_SECOND: cfg_magic_second   = value[7:0];
         sfd_pkg::REG_VERSION:      cfg_version        = value[7:0];
         sfd_pkg::REG_SAMPLE_TYPE:  cfg_sample_type    = value[7:0];
         sfd_pkg::REG_HEARTBEAT:    cfg_heartbeat_type = value[7:0];
         sfd_pkg::REG_MAX_FRAME:    cfg_max_frame      = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] m0, input logic [7:0] m1,
                             input logic [7:0] ver, input logic [7:0] st,
                             input logic [7:0] hb,
                             input logic [sfd_pkg::MAX_LEN_WIDTH-1:0] max_len);
      write_reg(sfd_pkg::REG_MAGIC_FIRST, {9'd0, m0});
      write_reg(sfd_pkg::REG_MAGIC_SECOND, {9'd0, m1});
      write_reg(sfd_pkg::REG_VERSION, {9'd0, ver});
      write_reg(sfd_pkg::REG_SAMPLE_TYPE, {9'd0, st});
      write_reg(sfd_pkg::REG_HEARTBEAT, {9'd0, hb});
      write_reg(sfd_pkg::REG_MAX_FRAME, max_len);
      csr_wr_en <= 1'b0;
   endtask

   // Header with the current magic and version and the given type, random fields, random payload.
   task automatic make_body(input logic [7:0] type_code, input logic [7:0] ch,
                            input logic [7:0] spc);
      frame_buf.delete();
      frame_buf.push_back(cfg_magic_first);
      frame_buf.push_back(cfg_magic_second);
      frame_buf.push_back(cfg_version);
      frame_buf.push_back(type_code);
      for (int i = 4; i < 22; i++) begin
         frame_buf.push_back(8'($urandom));
      end
      frame_buf.push_back(ch);
      frame_buf.push_back(spc);
      for (int i = 0; i < 2 * int'(ch) * int'(spc); i++) begin
         frame_buf.push_back(8'($urandom));
      end
   endtask

   task automatic append_crc();
      logic [15:0] c;
      c = sfd_pkg::CRC_INIT;
      foreach (frame_buf[i]) begin
         c = crc_update(c, frame_buf[i]);
      end
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic flip_bit(input int pos, input int bitpos);
      frame_buf[pos] = frame_buf[pos] ^ (8'h01 << bitpos);
   endtask

   task automatic test_reset_values();
      // All codes are zero after reset, so a zero type is both a sample block and a heartbeat.
      make_body(8'h00, 8'd1, 8'd1);
      append_crc();
      send_frame();
      drain_results();
   endtask

   task automatic test_frame_types();
      set_config(8'hA5, 8'h5A, 8'h01, TYPE_SAMPLES, TYPE_HEARTBEAT, sfd_pkg::MAX_FRAME_INIT);
      make_body(TYPE_SAMPLES, 8'd2, 8'd2);
      frame_buf[24] = 8'h00; frame_buf[25] = 8'h80;
      frame_buf[26] = 8'hFF; frame_buf[27] = 8'h7F;
      frame_buf[28] = 8'hFF; frame_buf[29] = 8'hFF;
      frame_buf[30] = 8'h00; frame_buf[31] = 8'h00;
      append_crc();
      send_frame();
      make_body(TYPE_HEARTBEAT, 8'd0, 8'd0);
      for (int i = 4; i < 22; i++) frame_buf[i] = 8'hFF;
      append_crc();
      send_frame();
      make_body(TYPE_HEARTBEAT, 8'd0, 8'd0);
      for (int i = 4; i < 22; i++) frame_buf[i] = 8'h00;
      append_crc();
      send_frame();
      make_body(8'h30, 8'd1, 8'd1);
      append_crc();
      send_frame();
      // A corrupted received CRC and a corrupted payload byte both give a CRC mismatch.
      make_body(TYPE_SAMPLES, 8'd1, 8'd1);
      append_crc();
      flip_bit(frame_buf.size() - 1, 7);
      send_frame();
      make_body(TYPE_SAMPLES, 8'd1, 8'd2);
      append_crc();
      flip_bit(25, 0);
      send_frame();
      drain_results();
      set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, sfd_pkg::MAX_FRAME_INIT);
      make_body(8'hFF, 8'd1, 8'd1);
      append_crc();
      send_frame();
      make_body(8'h00, 8'd0, 8'd0);
      append_crc();
      send_frame();
      drain_results();
   endtask

   task automatic test_header_checks();
      set_config(8'h3C, 8'hC3, 8'h02, TYPE_SAMPLES, TYPE_HEARTBEAT, sfd_pkg::MAX_FRAME_INIT);
      // Samples still come out when the header fails; only the verdict flags it.
      for (int k = 0; k < 3; k++) begin
         make_body(TYPE_SAMPLES, 8'd1, 8'd2);
         flip_bit(k, k + 2);
         append_crc();
         send_frame();
      end
      drain_results();
   endtask

   task automatic test_length_errors();
      // Short frames: header bytes that never arrived read as zero.
      make_body(TYPE_SAMPLES, 8'd3, 8'd1);
      while (frame_buf.size() > 1) void'(frame_buf.pop_back());
      send_frame();
      make_body(TYPE_SAMPLES, 8'd3, 8'd1);
      while (frame_buf.size() > 24) void'(frame_buf.pop_back());
      send_frame();
      make_body(TYPE_SAMPLES, 8'd3, 8'd1);
      while (frame_buf.size() > 25) void'(frame_buf.pop_back());
      send_frame();
      // The end byte completes a sample, which must not be emitted.
      make_body(TYPE_SAMPLES, 8'd1, 8'd2);
      send_frame();
      make_body(TYPE_SAMPLES, 8'd1, 8'd2);
      append_crc();
      frame_buf.push_back(8'($urandom));
      send_frame();
      make_body(TYPE_SAMPLES, 8'd2, 8'd1);
      void'(frame_buf.pop_back());
      append_crc();
      send_frame();
      drain_results();
   endtask

   task automatic test_max_frame();
      write_reg(sfd_pkg::REG_MAX_FRAME, 17'(sfd_pkg::MIN_FRAME_LEN));
      csr_wr_en <= 1'b0;
      make_body(TYPE_HEARTBEAT, 8'd0, 8'd0);
      append_crc();
      send_frame();
      make_body(TYPE_SAMPLES, 8'd1, 8'd1);
      append_crc();
      send_frame();
      drain_results();
      write_reg(sfd_pkg::REG_MAX_FRAME, 17'h1FFFF);
      csr_wr_en <= 1'b0;
      make_body(TYPE_SAMPLES, 8'd1, 8'd1);
      append_crc();
      send_frame();
      drain_results();
      write_reg(sfd_pkg::REG_MAX_FRAME, sfd_pkg::MAX_FRAME_INIT);
      csr_wr_en <= 1'b0;
      // A longer frame with no idling on either side.
      idle_enable = 1'b0;
      make_body(TYPE_SAMPLES, 8'd4, 8'd8);
      append_crc();
      send_frame();
      drain_results();
      idle_enable = 1'b1;
   endtask

   task automatic test_unmapped_registers();
      write_reg(REG_UNMAPPED_LO, 17'h1FFFF);
      write_reg(REG_UNMAPPED_HI, 17'h00000);
      csr_wr_en <= 1'b0;
      make_body(TYPE_SAMPLES, 8'd1, 8'd1);
      append_crc();
      send_frame();
      drain_results();
   endtask

   task automatic randomize_config();
      write_reg(sfd_pkg::REG_MAGIC_FIRST, 17'($urandom));
      write_reg(sfd_pkg::REG_MAGIC_SECOND, 17'($urandom));
      write_reg(sfd_pkg::REG_VERSION, 17'($urandom));
      write_reg(sfd_pkg::REG_SAMPLE_TYPE, 17'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         write_reg(sfd_pkg::REG_HEARTBEAT, {9'd0, cfg_sample_type});
      end else begin
         write_reg(sfd_pkg::REG_HEARTBEAT, 17'($urandom));
      end
      case ($urandom_range(0, 3))
         0: write_reg(sfd_pkg::REG_MAX_FRAME, 17'(sfd_pkg::MIN_FRAME_LEN));
         1: write_reg(sfd_pkg::REG_MAX_FRAME, 17'($urandom_range(26, 80)));
         default: write_reg(sfd_pkg::REG_MAX_FRAME, sfd_pkg::MAX_FRAME_INIT);
      endcase
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_random_frames();
      int unsigned start_count;
      int          pick;
      int          cut;
      logic [7:0]  ch;
      logic [7:0]  spc;
      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         if ($urandom_range(0, 3) == 0) begin
            drain_results();
            randomize_config();
         end
         idle_enable = ($urandom_range(0, 7) != 0);
         pick = $urandom_range(0, 99);
         if (pick >= 95) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
         end else begin
            ch  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 12)) :
                                                8'($urandom_range(0, 4));
            spc = 8'($urandom_range(0, 4));
            make_body(($urandom_range(0, 1) != 0) ? cfg_sample_type : cfg_heartbeat_type,
                      ch, spc);
            append_crc();
            if (pick >= 88) begin
               repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
            end else if (pick >= 80) begin
               cut = $urandom_range(1, frame_buf.size() - 1);
               while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            end else if (pick >= 70) begin
               flip_bit($urandom_range(0, frame_buf.size() - 1), $urandom_range(0, 7));
            end
         end
         send_frame();
      end
      drain_results();
      idle_enable = 1'b1;
   endtask

   initial begin
      clear_frame();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_frame_types();
      test_header_checks();
      test_length_errors();
      test_max_frame();
      test_unmapped_registers();
      test_random_frames();
      drain_results();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sample_frame_deframer_crc16.f */
rtl/core/sfd_pkg.sv
rtl/core/sfd_crc16.sv
rtl/core/sample_frame_deframer_crc16.sv
test/tb_sample_frame_deframer_crc16.sv
